// File: rtl/core/wes_pkg.sv
// ============================================================================
// wes_pkg: shared types and constants of the wave equation stencil core
// Payload structs, configuration indexes, reset values, controller states
// and the command and status groups between controller and datapath.
// ============================================================================
package wes_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int VAL_W      = 64;
    localparam int HALF_W     = VAL_W / 2;
    localparam int ACC_W      = VAL_W + HALF_W;
    localparam int PTS_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int MIN_POINTS = 3;
    localparam int MUL_CNT_W  = 3;

    // Last step of the iterative multiplier: four partial products and a sign fix.
    localparam logic [MUL_CNT_W-1:0] MUL_LAST_STEP = MUL_CNT_W'(4);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_COEFF          = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAMMA_GAIN     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_NEIGHBOR_GAIN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAMMA_GAIN    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_NEIGHBOR_GAIN = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE       = CFG_IDX_W'(5);

    // Reset values of the configuration registers (Q32.32 where 64 bits).
    localparam logic [VAL_W-1:0] RST_WAVE_COEFF          = 64'h0000_0000_0000_68DC;
    localparam logic [VAL_W-1:0] RST_LEFT_GAMMA_GAIN     = 64'hFFFF_FFFF_E000_0000;
    localparam logic [VAL_W-1:0] RST_LEFT_NEIGHBOR_GAIN  = 64'h0000_0001_4000_0000;
    localparam logic [VAL_W-1:0] RST_RIGHT_GAMMA_GAIN    = 64'h0000_0001_0000_0000;
    localparam logic [VAL_W-1:0] RST_RIGHT_NEIGHBOR_GAIN = 64'h0000_0000_0000_0000;
    localparam logic [PTS_W-1:0] RST_POINTS_IN_USE       = PTS_W'(11);

    // Item operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [IDX_W-1:0]        point_index;
        logic signed [VAL_W-1:0] older_value;
        logic signed [VAL_W-1:0] newer_value;
        logic signed [VAL_W-1:0] source_term;
        logic signed [VAL_W-1:0] boundary_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_index;
        logic signed [VAL_W-1:0] new_value;
        logic                    row_done;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LD_NEW,
        S_RD_N0,
        S_RD_NP1,
        S_RD_OLD,
        S_LAP,
        S_WC_WAIT,
        S_MUL_LG,
        S_LG_WAIT,
        S_LN_WAIT,
        S_EMIT_EDGE,
        S_EMIT_V,
        S_R_WAIT1,
        S_R_WAIT2,
        S_EMIT_RIGHT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LD_OLD,
        DP_LD_NEW,
        DP_LATCH_LB,
        DP_RD_NM1,
        DP_RD_N0,
        DP_RD_NP1,
        DP_RD_OLD,
        DP_LAP,
        DP_INTERIOR,
        DP_MUL_LG,
        DP_MUL_LN,
        DP_LEFT,
        DP_MUL_RG,
        DP_MUL_RN,
        DP_RIGHT
    } dp_op_t;

    typedef enum logic [1:0] {
        OUT_LEFT_EDGE,
        OUT_POINT,
        OUT_RIGHT_EDGE
    } out_kind_t;

    typedef struct packed {
        dp_op_t    op;
        logic      out_load;
        out_kind_t out_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_op;
        logic in_range;
        logic is_zero;
        logic is_one;
        logic is_last;
        logic mul_busy;
        logic mul_done;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/wes_qmul.sv
// ============================================================================
// wes_qmul: iterative signed Q32.32 multiplier
// Forms the four 32x32 partial products one per cycle, accumulates them and
// applies the two's complement correction; result is floor(a*b/2^32) mod 2^64.
// ============================================================================
module wes_qmul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wes_pkg::VAL_W-1:0] a,
    input  logic [wes_pkg::VAL_W-1:0] b,
    output logic                      busy,
    output logic                      done,
    output logic [wes_pkg::VAL_W-1:0] result
);

    logic [wes_pkg::VAL_W-1:0]     a_reg;
    logic [wes_pkg::VAL_W-1:0]     b_reg;
    logic [wes_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic [wes_pkg::MUL_CNT_W-1:0] cnt_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [wes_pkg::VAL_W-1:0]     prod_reg;
    logic [wes_pkg::VAL_W-1:0]     prod_next;
    logic [wes_pkg::ACC_W-1:0]     acc_reg;
    logic [wes_pkg::ACC_W-1:0]     acc_next;
    logic [wes_pkg::HALF_W-1:0]    op_x;
    logic [wes_pkg::HALF_W-1:0]    op_y;
    logic [wes_pkg::HALF_W-1:0]    corr;

    always_comb
    begin
        case (cnt_reg)
            wes_pkg::MUL_CNT_W'(0):
            begin
                op_x = a_reg[wes_pkg::HALF_W-1:0];
                op_y = b_reg[wes_pkg::HALF_W-1:0];
            end
            wes_pkg::MUL_CNT_W'(1):
            begin
                op_x = a_reg[wes_pkg::HALF_W-1:0];
                op_y = b_reg[wes_pkg::VAL_W-1:wes_pkg::HALF_W];
            end
            wes_pkg::MUL_CNT_W'(2):
            begin
                op_x = a_reg[wes_pkg::VAL_W-1:wes_pkg::HALF_W];
                op_y = b_reg[wes_pkg::HALF_W-1:0];
            end
            default:
            begin
                op_x = a_reg[wes_pkg::VAL_W-1:wes_pkg::HALF_W];
                op_y = b_reg[wes_pkg::VAL_W-1:wes_pkg::HALF_W];
            end
        endcase
        prod_next = op_x * op_y;
    end

    // A negative operand adds 2^64 times the other one to the unsigned product;
    // only its low half lands inside the 96 bits that are kept.
    always_comb
    begin
        corr = (a_reg[wes_pkg::VAL_W-1] ? b_reg[wes_pkg::HALF_W-1:0] : '0)
             + (b_reg[wes_pkg::VAL_W-1] ? a_reg[wes_pkg::HALF_W-1:0] : '0);
    end

    always_comb
    begin
        acc_next = acc_reg;
        case (cnt_reg)
            wes_pkg::MUL_CNT_W'(1):
                acc_next = {{wes_pkg::HALF_W{1'b0}}, prod_reg};
            wes_pkg::MUL_CNT_W'(2),
            wes_pkg::MUL_CNT_W'(3):
                acc_next = acc_reg + {prod_reg, {wes_pkg::HALF_W{1'b0}}};
            wes_pkg::MUL_LAST_STEP:
                acc_next = {acc_reg[wes_pkg::ACC_W-1:wes_pkg::VAL_W]
                                + prod_reg[wes_pkg::HALF_W-1:0] - corr,
                            acc_reg[wes_pkg::VAL_W-1:0]};
            default:
                acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == wes_pkg::MUL_LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (busy_reg)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg[wes_pkg::ACC_W-1:wes_pkg::HALF_W];

endmodule

// File: rtl/core/wes_dp.sv
// ============================================================================
// wes_dp: datapath of the wave equation stencil core
// Configuration registers, the two-row value memory, operand registers, the
// shared multiplier and the output register, all steered by controller commands.
// ============================================================================
module wes_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wes_pkg::in_item_t             in_item,
    input  logic                          cfg_we,
    input  logic [wes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wes_pkg::VAL_W-1:0]     cfg_data,
    input  wes_pkg::ctrl_cmd_t            cmd,
    output wes_pkg::dp_status_t           status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wes_pkg::out_item_t            out_item
);

    // Configuration
    logic [wes_pkg::VAL_W-1:0] wave_coeff_reg;
    logic [wes_pkg::VAL_W-1:0] left_gamma_reg;
    logic [wes_pkg::VAL_W-1:0] left_neighbor_reg;
    logic [wes_pkg::VAL_W-1:0] right_gamma_reg;
    logic [wes_pkg::VAL_W-1:0] right_neighbor_reg;
    logic [wes_pkg::PTS_W-1:0] points_reg;
    logic [wes_pkg::PTS_W-1:0] points_eff;

    // Row state
    logic                      sel_reg;
    logic [wes_pkg::VAL_W-1:0] hlb_reg;

    // Value memory: the bank bit is the address MSB, bank 0 is row a.
    logic [wes_pkg::VAL_W-1:0]  mem [0:2*wes_pkg::MAX_POINTS-1];
    logic [wes_pkg::VAL_W-1:0]  rd_data_reg;
    logic                       rd_en;
    logic [wes_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [wes_pkg::ADDR_W-1:0] wr_addr;
    logic [wes_pkg::VAL_W-1:0]  wr_data;

    // Work registers
    wes_pkg::in_item_t         item_reg;
    logic [wes_pkg::IDX_W-1:0] idx;
    logic [wes_pkg::VAL_W-1:0] nm1_reg;
    logic [wes_pkg::VAL_W-1:0] n0_reg;
    logic [wes_pkg::VAL_W-1:0] np1_reg;
    logic [wes_pkg::VAL_W-1:0] base_reg;
    logic [wes_pkg::VAL_W-1:0] v_reg;
    logic [wes_pkg::VAL_W-1:0] sum_reg;
    logic [wes_pkg::VAL_W-1:0] res_reg;
    logic [wes_pkg::VAL_W-1:0] lap;
    logic [wes_pkg::VAL_W-1:0] point_sum;
    logic [wes_pkg::VAL_W-1:0] edge_sum;

    // Multiplier
    logic                      mul_start;
    logic [wes_pkg::VAL_W-1:0] mul_a;
    logic [wes_pkg::VAL_W-1:0] mul_b;
    logic                      mul_busy;
    logic                      mul_done;
    logic [wes_pkg::VAL_W-1:0] mul_result;

    // Output register
    logic                  out_valid_reg;
    wes_pkg::out_item_t    out_item_reg;
    wes_pkg::out_item_t    out_item_next;
    logic                  out_free;

    assign idx = item_reg.point_index;

    always_comb
    begin
        if (points_reg < wes_pkg::PTS_W'(wes_pkg::MIN_POINTS))
            points_eff = wes_pkg::PTS_W'(wes_pkg::MIN_POINTS);
        else if (points_reg > wes_pkg::PTS_W'(wes_pkg::MAX_POINTS))
            points_eff = wes_pkg::PTS_W'(wes_pkg::MAX_POINTS);
        else
            points_eff = points_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_coeff_reg     <= wes_pkg::RST_WAVE_COEFF;
            left_gamma_reg     <= wes_pkg::RST_LEFT_GAMMA_GAIN;
            left_neighbor_reg  <= wes_pkg::RST_LEFT_NEIGHBOR_GAIN;
            right_gamma_reg    <= wes_pkg::RST_RIGHT_GAMMA_GAIN;
            right_neighbor_reg <= wes_pkg::RST_RIGHT_NEIGHBOR_GAIN;
            points_reg         <= wes_pkg::RST_POINTS_IN_USE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wes_pkg::CFG_WAVE_COEFF:          wave_coeff_reg     <= cfg_data;
                wes_pkg::CFG_LEFT_GAMMA_GAIN:     left_gamma_reg     <= cfg_data;
                wes_pkg::CFG_LEFT_NEIGHBOR_GAIN:  left_neighbor_reg  <= cfg_data;
                wes_pkg::CFG_RIGHT_GAMMA_GAIN:    right_gamma_reg    <= cfg_data;
                wes_pkg::CFG_RIGHT_NEIGHBOR_GAIN: right_neighbor_reg <= cfg_data;
                wes_pkg::CFG_POINTS_IN_USE:
                    points_reg <= cfg_data[wes_pkg::PTS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign lap       = np1_reg - {n0_reg[wes_pkg::VAL_W-2:0], 1'b0} + nm1_reg;
    assign point_sum = base_reg + mul_result;
    assign edge_sum  = sum_reg + mul_result;

    // Memory port and multiplier operand selection.
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = {sel_reg, idx};
        wr_en     = 1'b0;
        wr_addr   = {~sel_reg, idx};
        wr_data   = point_sum;
        mul_start = 1'b0;
        mul_a     = wave_coeff_reg;
        mul_b     = lap;
        unique case (cmd.op)
            wes_pkg::DP_LD_OLD:
            begin
                wr_en   = 1'b1;
                wr_data = item_reg.older_value;
            end
            wes_pkg::DP_LD_NEW:
            begin
                wr_en   = 1'b1;
                wr_addr = {sel_reg, idx};
                wr_data = item_reg.newer_value;
            end
            wes_pkg::DP_RD_NM1:
            begin
                rd_en   = 1'b1;
                rd_addr = {sel_reg, idx - 1'b1};
            end
            wes_pkg::DP_RD_N0:
            begin
                rd_en = 1'b1;
            end
            wes_pkg::DP_RD_NP1:
            begin
                rd_en   = 1'b1;
                rd_addr = {sel_reg, idx + 1'b1};
            end
            wes_pkg::DP_RD_OLD:
            begin
                rd_en   = 1'b1;
                rd_addr = {~sel_reg, idx};
            end
            wes_pkg::DP_LAP:
            begin
                mul_start = 1'b1;
            end
            wes_pkg::DP_INTERIOR:
            begin
                wr_en = 1'b1;
            end
            wes_pkg::DP_MUL_LG:
            begin
                mul_start = 1'b1;
                mul_a     = left_gamma_reg;
                mul_b     = hlb_reg;
            end
            wes_pkg::DP_MUL_LN:
            begin
                mul_start = 1'b1;
                mul_a     = left_neighbor_reg;
                mul_b     = v_reg;
            end
            wes_pkg::DP_LEFT:
            begin
                wr_en   = 1'b1;
                wr_addr = {~sel_reg, wes_pkg::IDX_W'(0)};
                wr_data = edge_sum;
            end
            wes_pkg::DP_MUL_RG:
            begin
                mul_start = 1'b1;
                mul_a     = right_gamma_reg;
                mul_b     = item_reg.boundary_value;
                rd_en     = 1'b1;
                rd_addr   = {~sel_reg, idx - 1'b1};
            end
            wes_pkg::DP_MUL_RN:
            begin
                mul_start = 1'b1;
                mul_a     = right_neighbor_reg;
                mul_b     = rd_data_reg;
            end
            wes_pkg::DP_RIGHT:
            begin
                wr_en   = 1'b1;
                wr_data = edge_sum;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    wes_qmul u_qmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_result)
    );

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            wes_pkg::DP_CAPTURE:  item_reg <= in_item;
            wes_pkg::DP_RD_N0:    nm1_reg  <= rd_data_reg;
            wes_pkg::DP_RD_NP1:   n0_reg   <= rd_data_reg;
            wes_pkg::DP_RD_OLD:   np1_reg  <= rd_data_reg;
            wes_pkg::DP_LAP:
                base_reg <= {n0_reg[wes_pkg::VAL_W-2:0], 1'b0} - rd_data_reg
                          + item_reg.source_term;
            wes_pkg::DP_INTERIOR: v_reg    <= point_sum;
            wes_pkg::DP_MUL_LN:   sum_reg  <= mul_result;
            wes_pkg::DP_MUL_RN:   sum_reg  <= mul_result;
            wes_pkg::DP_LEFT:     res_reg  <= edge_sum;
            wes_pkg::DP_RIGHT:    res_reg  <= edge_sum;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
            hlb_reg <= '0;
        end
        else
        begin
            if (cmd.op == wes_pkg::DP_LATCH_LB)
                hlb_reg <= item_reg.boundary_value;
            if (cmd.op == wes_pkg::DP_RIGHT)
                sel_reg <= ~sel_reg;
        end
    end

    // Output register: a new result may be loaded in the cycle the old one transfers.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (cmd.out_kind)
            wes_pkg::OUT_LEFT_EDGE:
                out_item_next = '{out_index: wes_pkg::IDX_W'(0), new_value: res_reg,
                                  row_done: 1'b0};
            wes_pkg::OUT_POINT:
                out_item_next = '{out_index: idx, new_value: v_reg, row_done: 1'b0};
            wes_pkg::OUT_RIGHT_EDGE:
                out_item_next = '{out_index: idx, new_value: res_reg, row_done: 1'b1};
            default:
                out_item_next = '{out_index: idx, new_value: res_reg, row_done: 1'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        status.item_op  = item_reg.operation;
        status.in_range = {1'b0, idx} < points_eff;
        status.is_zero  = idx == wes_pkg::IDX_W'(0);
        status.is_one   = idx == wes_pkg::IDX_W'(1);
        status.is_last  = {1'b0, idx} == (points_eff - 1'b1);
        status.mul_busy = mul_busy;
        status.mul_done = mul_done;
        status.out_free = out_free;
    end

endmodule

// File: rtl/core/wes_ctrl.sv
// ============================================================================
// wes_ctrl: controller of the wave equation stencil core
// Sequences loads, stencil reads, multiplies, memory writes and result
// transfers by issuing one datapath command per cycle.
// ============================================================================
module wes_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wes_pkg::dp_status_t status,
    output wes_pkg::ctrl_cmd_t  cmd
);

    wes_pkg::ctrl_state_t state_reg;
    wes_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wes_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wes_pkg::S_IDLE:
                if (in_valid)
                    state_next = wes_pkg::S_DECODE;
            wes_pkg::S_DECODE:
            begin
                if (status.item_op == wes_pkg::OP_LOAD)
                    state_next = wes_pkg::S_LD_NEW;
                else if (!status.in_range || status.is_zero)
                    state_next = wes_pkg::S_IDLE;
                else if (status.is_last)
                    state_next = wes_pkg::S_R_WAIT1;
                else
                    state_next = wes_pkg::S_RD_N0;
            end
            wes_pkg::S_LD_NEW:  state_next = wes_pkg::S_IDLE;
            wes_pkg::S_RD_N0:   state_next = wes_pkg::S_RD_NP1;
            wes_pkg::S_RD_NP1:  state_next = wes_pkg::S_RD_OLD;
            wes_pkg::S_RD_OLD:  state_next = wes_pkg::S_LAP;
            wes_pkg::S_LAP:     state_next = wes_pkg::S_WC_WAIT;
            wes_pkg::S_WC_WAIT:
                if (status.mul_done)
                    state_next = status.is_one ? wes_pkg::S_MUL_LG : wes_pkg::S_EMIT_V;
            wes_pkg::S_MUL_LG:  state_next = wes_pkg::S_LG_WAIT;
            wes_pkg::S_LG_WAIT:
                if (status.mul_done)
                    state_next = wes_pkg::S_LN_WAIT;
            wes_pkg::S_LN_WAIT:
                if (status.mul_done)
                    state_next = wes_pkg::S_EMIT_EDGE;
            wes_pkg::S_EMIT_EDGE:
                if (status.out_free)
                    state_next = wes_pkg::S_EMIT_V;
            wes_pkg::S_EMIT_V:
                if (status.out_free)
                    state_next = wes_pkg::S_IDLE;
            wes_pkg::S_R_WAIT1:
                if (status.mul_done)
                    state_next = wes_pkg::S_R_WAIT2;
            wes_pkg::S_R_WAIT2:
                if (status.mul_done)
                    state_next = wes_pkg::S_EMIT_RIGHT;
            wes_pkg::S_EMIT_RIGHT:
                if (status.out_free)
                    state_next = wes_pkg::S_IDLE;
            default:
                state_next = wes_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        cmd.op       = wes_pkg::DP_NOP;
        cmd.out_load = 1'b0;
        cmd.out_kind = wes_pkg::OUT_POINT;
        unique case (state_reg)
            wes_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    cmd.op = wes_pkg::DP_CAPTURE;
            end
            wes_pkg::S_DECODE:
            begin
                if (status.item_op == wes_pkg::OP_LOAD)
                    cmd.op = wes_pkg::DP_LD_OLD;
                else if (!status.in_range)
                    cmd.op = wes_pkg::DP_NOP;
                else if (status.is_zero)
                    cmd.op = wes_pkg::DP_LATCH_LB;
                else if (status.is_last)
                    cmd.op = wes_pkg::DP_MUL_RG;
                else
                    cmd.op = wes_pkg::DP_RD_NM1;
            end
            wes_pkg::S_LD_NEW:  cmd.op = wes_pkg::DP_LD_NEW;
            wes_pkg::S_RD_N0:   cmd.op = wes_pkg::DP_RD_N0;
            wes_pkg::S_RD_NP1:  cmd.op = wes_pkg::DP_RD_NP1;
            wes_pkg::S_RD_OLD:  cmd.op = wes_pkg::DP_RD_OLD;
            wes_pkg::S_LAP:     cmd.op = wes_pkg::DP_LAP;
            wes_pkg::S_WC_WAIT:
                if (status.mul_done)
                    cmd.op = wes_pkg::DP_INTERIOR;
            wes_pkg::S_MUL_LG:  cmd.op = wes_pkg::DP_MUL_LG;
            wes_pkg::S_LG_WAIT:
                if (status.mul_done)
                    cmd.op = wes_pkg::DP_MUL_LN;
            wes_pkg::S_LN_WAIT:
                if (status.mul_done)
                    cmd.op = wes_pkg::DP_LEFT;
            wes_pkg::S_EMIT_EDGE:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = wes_pkg::OUT_LEFT_EDGE;
            end
            wes_pkg::S_EMIT_V:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = wes_pkg::OUT_POINT;
            end
            wes_pkg::S_R_WAIT1:
                if (status.mul_done)
                    cmd.op = wes_pkg::DP_MUL_RN;
            wes_pkg::S_R_WAIT2:
                if (status.mul_done)
                    cmd.op = wes_pkg::DP_RIGHT;
            wes_pkg::S_EMIT_RIGHT:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = wes_pkg::OUT_RIGHT_EDGE;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == wes_pkg::S_DECODE))
        else $error("accepted item did not move the controller to decode");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register loaded while a stalled result is held");

    a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wes_pkg::S_IDLE) |-> !status.mul_busy)
        else $error("multiplier still busy while the controller is idle");

    a_mul_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == wes_pkg::DP_LAP || cmd.op == wes_pkg::DP_MUL_LG
         || cmd.op == wes_pkg::DP_MUL_LN || cmd.op == wes_pkg::DP_MUL_RG
         || cmd.op == wes_pkg::DP_MUL_RN) |=> status.mul_busy)
        else $error("multiply command did not start the multiplier");
`endif

endmodule

// File: rtl/core/wave_equation_stencil_step_core.sv
// ============================================================================
// wave_equation_stencil_step_core: one explicit time level of the 1-D wave
// equation, point by point, with first-order Robin edges in Q32.32.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    wes_pkg::in_item_t
//   out      output     out_valid / out_stall  wes_pkg::out_item_t
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item is worked on at a time. The pace is set by the iterative 64-bit
// multiplier (four 32x32 partial products per multiply) and the single memory
// read port. The value rows are not cleared by reset and come up undefined.
// A stalled result waits in the output register while the next item is taken.
// ============================================================================
module wave_equation_stencil_step_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  wes_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wes_pkg::out_item_t            out_item,
    input  logic                          cfg_we,
    input  logic [wes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wes_pkg::VAL_W-1:0]     cfg_data
);

    wes_pkg::ctrl_cmd_t  cmd;
    wes_pkg::dp_status_t status;

    wes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wes_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: bench/wave_equation_stencil_step_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// wave_equation_stencil_step_core_tb: self-checking bench of the stencil core
// Fills both value rows, walks a short table of directed items, then runs
// configuration phases of full rows, broken rows and noise. Every result is
// compared with an in-bench model of the time stepping, with bursty input
// and a receiver that stalls on its own pattern.
// ============================================================================
module wave_equation_stencil_step_core_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_ITEMS   = 1850;

    localparam logic [wes_pkg::VAL_W-1:0] Q_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [wes_pkg::VAL_W-1:0] Q_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [wes_pkg::VAL_W-1:0] Q_ONE  = 64'h0000_0001_0000_0000;
    localparam logic [wes_pkg::VAL_W-1:0] Q_HALF = 64'h0000_0000_8000_0000;
    localparam logic [wes_pkg::VAL_W-1:0] Q_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [wes_pkg::VAL_W-1:0] Q_ZERO = 64'h0;

    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [wes_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = wes_pkg::CFG_IDX_W'(6);
    localparam logic [wes_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = wes_pkg::CFG_IDX_W'(7);

    typedef enum logic [1:0] {CHK_MODEL, CHK_SILENT, CHK_EDGE} chk_t;
    typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_HOLD} rx_mode_t;

    typedef struct packed {
        logic                      op;
        logic [wes_pkg::IDX_W-1:0] idx;
        logic [wes_pkg::VAL_W-1:0] older;
        logic [wes_pkg::VAL_W-1:0] newer;
        logic [wes_pkg::VAL_W-1:0] source;
        logic [wes_pkg::VAL_W-1:0] bound;
        chk_t                      chk;
        logic [wes_pkg::VAL_W-1:0] right_val;
    } dir_row_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    wes_pkg::in_item_t             in_item   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    wes_pkg::out_item_t            out_item;
    logic                          cfg_we    = 1'b0;
    logic [wes_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wes_pkg::VAL_W-1:0]     cfg_data  = '0;

    wave_equation_stencil_step_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Model of the grid: two rows, the select of the newest one and the latches.
    logic [wes_pkg::VAL_W-1:0] level_row [2][wes_pkg::MAX_POINTS];
    logic                      newest_sel;
    logic [wes_pkg::VAL_W-1:0] held_left_bound;
    logic [wes_pkg::VAL_W-1:0] held_prev_old;
    logic [wes_pkg::VAL_W-1:0] gain_wave;
    logic [wes_pkg::VAL_W-1:0] gain_left_gamma;
    logic [wes_pkg::VAL_W-1:0] gain_left_nb;
    logic [wes_pkg::VAL_W-1:0] gain_right_gamma;
    logic [wes_pkg::VAL_W-1:0] gain_right_nb;
    logic [wes_pkg::PTS_W-1:0] pts_cfg;

    wes_pkg::out_item_t expected_points [$];
    dir_row_t           dir_tab [22];

    int mismatches      = 0;
    int results_seen    = 0;
    int items_moved     = 0;
    int effective_items = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;
    int stall_left      = 0;
    rx_mode_t stall_mode = RX_FREE;

    // Q32.32 product: full signed product, floor shift by 32, low 64 bits kept.
    function automatic logic [wes_pkg::VAL_W-1:0] q_mul(logic [wes_pkg::VAL_W-1:0] a,
                                                        logic [wes_pkg::VAL_W-1:0] b);
        logic signed [2*wes_pkg::VAL_W-1:0] wa;
        logic signed [2*wes_pkg::VAL_W-1:0] wb;
        logic signed [2*wes_pkg::VAL_W-1:0] prod;
        wa   = $signed(a);
        wb   = $signed(b);
        prod = wa * wb;
        return prod[wes_pkg::VAL_W+wes_pkg::HALF_W-1:wes_pkg::HALF_W];
    endfunction

    function automatic int active_points();
        int p;
        p = int'(pts_cfg);
        if (p < wes_pkg::MIN_POINTS)
            p = wes_pkg::MIN_POINTS;
        if (p > wes_pkg::MAX_POINTS)
            p = wes_pkg::MAX_POINTS;
        return p;
    endfunction

    function automatic int predict_new_level(input wes_pkg::in_item_t it,
                                             output wes_pkg::out_item_t res [2]);
        int                        p;
        int                        i;
        logic                      nsel;
        logic                      osel;
        logic [wes_pkg::VAL_W-1:0] lap;
        logic [wes_pkg::VAL_W-1:0] v;
        logic [wes_pkg::VAL_W-1:0] left_val;
        logic [wes_pkg::VAL_W-1:0] n0;
        res[0] = '0;
        res[1] = '0;
        i      = int'(it.point_index);
        nsel   = newest_sel;
        osel   = ~newest_sel;
        if (it.operation == wes_pkg::OP_LOAD)
        begin
            level_row[osel][i] = it.older_value;
            level_row[nsel][i] = it.newer_value;
            return 0;
        end
        p = active_points();
        if (i >= p)
            return 0;
        if (i == 0)
        begin
            held_left_bound = it.boundary_value;
            return 0;
        end
        if (i == p - 1)
        begin
            held_prev_old = level_row[osel][i];
            v = q_mul(gain_right_gamma, it.boundary_value)
                + q_mul(gain_right_nb, level_row[osel][i-1]);
            level_row[osel][i] = v;
            newest_sel = ~newest_sel;
            res[0].out_index = wes_pkg::IDX_W'(i);
            res[0].new_value = v;
            res[0].row_done  = 1'b1;
            return 1;
        end
        held_prev_old = level_row[osel][i];
        n0  = level_row[nsel][i];
        lap = level_row[nsel][i+1] - (n0 << 1) + level_row[nsel][i-1];
        v   = (n0 << 1) - held_prev_old + q_mul(gain_wave, lap) + it.source_term;
        level_row[osel][i] = v;
        if (i == 1)
        begin
            // The left edge depends on the fresh value at point one.
            left_val = q_mul(gain_left_gamma, held_left_bound) + q_mul(gain_left_nb, v);
            level_row[osel][0] = left_val;
            res[0].out_index = '0;
            res[0].new_value = left_val;
            res[0].row_done  = 1'b0;
            res[1].out_index = wes_pkg::IDX_W'(1);
            res[1].new_value = v;
            res[1].row_done  = 1'b0;
            return 2;
        end
        res[0].out_index = wes_pkg::IDX_W'(i);
        res[0].new_value = v;
        res[0].row_done  = 1'b0;
        return 1;
    endfunction

    function automatic void apply_reg(logic [wes_pkg::CFG_IDX_W-1:0] idx,
                                      logic [wes_pkg::VAL_W-1:0] data);
        case (idx)
            wes_pkg::CFG_WAVE_COEFF:          gain_wave        = data;
            wes_pkg::CFG_LEFT_GAMMA_GAIN:     gain_left_gamma  = data;
            wes_pkg::CFG_LEFT_NEIGHBOR_GAIN:  gain_left_nb     = data;
            wes_pkg::CFG_RIGHT_GAMMA_GAIN:    gain_right_gamma = data;
            wes_pkg::CFG_RIGHT_NEIGHBOR_GAIN: gain_right_nb    = data;
            wes_pkg::CFG_POINTS_IN_USE:       pts_cfg          = data[wes_pkg::PTS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [wes_pkg::VAL_W-1:0] rand_q();
        logic [wes_pkg::VAL_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return r;
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return Q_ZERO;
                    default: return Q_ONES;
                endcase
            end
            9:       return {r[63:32], 32'h0};
            default: return {{28{r[35]}}, r[35:0]};
        endcase
    endfunction

    function automatic logic [wes_pkg::VAL_W-1:0] rand_gain();
        logic [wes_pkg::VAL_W-1:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            return r;
        return {{30{r[33]}}, r[33:0]};
    endfunction

    function automatic logic [wes_pkg::VAL_W-1:0] rand_points();
        logic [wes_pkg::VAL_W-1:0] r;
        logic [wes_pkg::PTS_W-1:0] p;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: p = wes_pkg::PTS_W'($urandom_range(3, 8));
            8, 9, 10, 11, 12, 13:   p = wes_pkg::PTS_W'($urandom_range(9, 20));
            14, 15, 16:             p = wes_pkg::PTS_W'($urandom_range(21, 64));
            17:                     p = wes_pkg::PTS_W'($urandom_range(0, 2));
            18:                     p = wes_pkg::PTS_W'($urandom_range(65, 127));
            default:
                p = ($urandom_range(0, 1) == 0) ? wes_pkg::PTS_W'(3) : wes_pkg::PTS_W'(64);
        endcase
        return {r[wes_pkg::VAL_W-1:wes_pkg::PTS_W], p};
    endfunction

    function automatic wes_pkg::in_item_t make_item(logic op, int idx);
        wes_pkg::in_item_t it;
        it.operation      = op;
        it.point_index    = wes_pkg::IDX_W'(idx);
        it.older_value    = rand_q();
        it.newer_value    = rand_q();
        it.source_term    = rand_q();
        it.boundary_value = rand_q();
        return it;
    endfunction

    // One input transfer in a bursty stream; expectations are queued on acceptance.
    task automatic transfer_item(input wes_pkg::in_item_t it, input chk_t chk,
                                 input logic [wes_pkg::VAL_W-1:0] right_val);
        wes_pkg::out_item_t res [2];
        wes_pkg::out_item_t typed;
        int                 n;
        int                 gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_moved++;
        if (!(it.operation == wes_pkg::OP_STEP && int'(it.point_index) >= active_points()))
            effective_items++;
        n = predict_new_level(it, res);
        case (chk)
            CHK_MODEL:
            begin
                for (int k = 0; k < n; k++)
                    expected_points = {expected_points, res[k]};
            end
            CHK_EDGE:
            begin
                typed.out_index = it.point_index;
                typed.new_value = right_val;
                typed.row_done  = 1'b1;
                expected_points = {expected_points, typed};
            end
            default: ;
        endcase
    endtask

    task automatic wait_results_drained(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_reg(input logic [wes_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wes_pkg::VAL_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic configure_phase(input int phase);
        logic [wes_pkg::VAL_W-1:0] ext [5];
        int                        forced [7];
        ext    = '{Q_MAX, Q_MIN, Q_ZERO, Q_ONES, Q_ONE};
        forced = '{3, 64, 0, 127, 2, 65, 1};
        if (phase < 7)
        begin
            // Early phases sweep every register through its extremes.
            set_reg(wes_pkg::CFG_WAVE_COEFF,          ext[phase % 5]);
            set_reg(wes_pkg::CFG_LEFT_GAMMA_GAIN,     ext[(phase + 1) % 5]);
            set_reg(wes_pkg::CFG_LEFT_NEIGHBOR_GAIN,  ext[(phase + 2) % 5]);
            set_reg(wes_pkg::CFG_RIGHT_GAMMA_GAIN,    ext[(phase + 3) % 5]);
            set_reg(wes_pkg::CFG_RIGHT_NEIGHBOR_GAIN, ext[(phase + 4) % 5]);
            set_reg(wes_pkg::CFG_POINTS_IN_USE,
                    wes_pkg::VAL_W'({{$urandom, $urandom} >> wes_pkg::PTS_W,
                                     wes_pkg::PTS_W'(forced[phase])}));
            if (phase == 2)
            begin
                set_reg(CFG_UNUSED_LO, {$urandom, $urandom});
                set_reg(CFG_UNUSED_HI, {$urandom, $urandom});
            end
        end
        else
        begin
            if ($urandom_range(0, 1) == 0)
                set_reg(wes_pkg::CFG_WAVE_COEFF,
                        ($urandom_range(0, 3) == 0) ? rand_gain() : {32'h0, $urandom});
            if ($urandom_range(0, 1) == 0)
                set_reg(wes_pkg::CFG_LEFT_GAMMA_GAIN, rand_gain());
            if ($urandom_range(0, 1) == 0)
                set_reg(wes_pkg::CFG_LEFT_NEIGHBOR_GAIN, rand_gain());
            if ($urandom_range(0, 1) == 0)
                set_reg(wes_pkg::CFG_RIGHT_GAMMA_GAIN, rand_gain());
            if ($urandom_range(0, 1) == 0)
                set_reg(wes_pkg::CFG_RIGHT_NEIGHBOR_GAIN, rand_gain());
            if ($urandom_range(0, 1) == 0)
                set_reg(wes_pkg::CFG_POINTS_IN_USE, rand_points());
            if ($urandom_range(0, 9) == 0)
                set_reg(($urandom_range(0, 1) == 0) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                        {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
    endtask

    // A row walked in point order, with stray loads; a broken row also drops,
    // misplaces or cuts off points.
    task automatic run_row(input bit broken);
        int p;
        p = active_points();
        for (int i = 0; i < p; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                transfer_item(make_item(wes_pkg::OP_LOAD,
                                        $urandom_range(0, wes_pkg::MAX_POINTS - 1)),
                              CHK_MODEL, Q_ZERO);
            if (broken && $urandom_range(0, 19) == 0)
                break;
            if (broken && $urandom_range(0, 5) == 0)
                transfer_item(make_item(wes_pkg::OP_STEP,
                                        $urandom_range(0, wes_pkg::MAX_POINTS - 1)),
                              CHK_MODEL, Q_ZERO);
            else
                transfer_item(make_item(wes_pkg::OP_STEP, i), CHK_MODEL, Q_ZERO);
        end
    endtask

    task automatic run_noise(input int count);
        repeat (count)
            transfer_item(make_item(($urandom_range(0, 1) == 0) ? wes_pkg::OP_LOAD
                                                                : wes_pkg::OP_STEP,
                                    $urandom_range(0, wes_pkg::MAX_POINTS - 1)),
                          CHK_MODEL, Q_ZERO);
    endtask

    // Receiver: free-running, choppy or solid stall stretches of random length.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = rx_mode_t'($urandom_range(0, 2));
            stall_left = (stall_mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            RX_FREE:   out_stall <= 1'b0;
            RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
            default:   out_stall <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin : result_check
        wes_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none pending: index %0d value %h done %b",
                         $time, out_item.out_index, out_item.new_value, out_item.row_done);
            end
            else
            begin
                want = expected_points.pop_front();
                if (out_item.out_index !== want.out_index)
                begin
                    mismatches++;
                    $display("%0t: out_index expected %0d actual %0d",
                             $time, want.out_index, out_item.out_index);
                end
                if (out_item.new_value !== want.new_value)
                begin
                    mismatches++;
                    $display("%0t: new_value at point %0d expected %h actual %h",
                             $time, want.out_index, want.new_value, out_item.new_value);
                end
                if (out_item.row_done !== want.row_done)
                begin
                    mismatches++;
                    $display("%0t: row_done at point %0d expected %b actual %b",
                             $time, want.out_index, want.row_done, out_item.row_done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[wave_equation_stencil_step_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int                phase;
        int                start_items;
        dir_row_t          row;
        wes_pkg::in_item_t it;
        // Default gains: right edge weight one, neighbor weight zero, so the
        // right-edge result equals the boundary value. Points in use: 11.
        dir_tab = '{
            '{wes_pkg::OP_STEP, 6'd0,  Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX,  CHK_SILENT, Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd1,  Q_ZERO, Q_ZERO, Q_MIN,  Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd2,  Q_ZERO, Q_ZERO, Q_MAX,  Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd3,  Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd4,  Q_ZERO, Q_ZERO, Q_ONES, Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd5,  Q_ZERO, Q_ZERO, Q_HALF, Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd6,  Q_ZERO, Q_ZERO, Q_ONE,  Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd7,  Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd8,  Q_ZERO, Q_ZERO, Q_HALF, Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd9,  Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd10, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN,  CHK_EDGE,   Q_MIN},
            '{wes_pkg::OP_STEP, 6'd11, Q_ZERO, Q_ZERO, Q_ONE,  Q_ONE,  CHK_SILENT, Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd63, Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX,  CHK_SILENT, Q_ZERO},
            '{wes_pkg::OP_LOAD, 6'd63, Q_MAX,  Q_MIN,  Q_ONES, Q_ONES, CHK_SILENT, Q_ZERO},
            '{wes_pkg::OP_LOAD, 6'd0,  Q_MIN,  Q_MAX,  Q_ZERO, Q_ZERO, CHK_SILENT, Q_ZERO},
            '{wes_pkg::OP_LOAD, 6'd5,  Q_ZERO, Q_ONES, Q_MIN,  Q_MAX,  CHK_SILENT, Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd5,  Q_ZERO, Q_ZERO, Q_ONE,  Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd1,  Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd10, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX,  CHK_EDGE,   Q_MAX},
            '{wes_pkg::OP_STEP, 6'd0,  Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN,  CHK_SILENT, Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd1,  Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, CHK_MODEL,  Q_ZERO},
            '{wes_pkg::OP_STEP, 6'd10, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, CHK_EDGE,   Q_ZERO}
        };
        gain_wave        = wes_pkg::RST_WAVE_COEFF;
        gain_left_gamma  = wes_pkg::RST_LEFT_GAMMA_GAIN;
        gain_left_nb     = wes_pkg::RST_LEFT_NEIGHBOR_GAIN;
        gain_right_gamma = wes_pkg::RST_RIGHT_GAMMA_GAIN;
        gain_right_nb    = wes_pkg::RST_RIGHT_NEIGHBOR_GAIN;
        pts_cfg          = wes_pkg::RST_POINTS_IN_USE;
        newest_sel       = 1'b0;
        held_left_bound  = '0;
        held_prev_old    = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both rows are written everywhere first, so no step reads an empty entry.
        for (int i = 0; i < wes_pkg::MAX_POINTS; i++)
            transfer_item(make_item(wes_pkg::OP_LOAD, i), CHK_MODEL, Q_ZERO);

        for (int i = 0; i < $size(dir_tab); i++)
        begin
            row               = dir_tab[i];
            it.operation      = row.op;
            it.point_index    = row.idx;
            it.older_value    = row.older;
            it.newer_value    = row.newer;
            it.source_term    = row.source;
            it.boundary_value = row.bound;
            transfer_item(it, row.chk, row.right_val);
        end

        start_items = effective_items;
        phase = 0;
        while (items_moved < RANDOM_ITEMS)
        begin
            // Registers change only with the core idle.
            wait_results_drained(SETTLE_CYCLES);
            configure_phase(phase);
            phase++;
            repeat ($urandom_range(1, (active_points() > 24) ? 2 : 4))
            begin
                case ($urandom_range(0, 9))
                    0:       run_noise($urandom_range(5, 25));
                    1, 2:    run_row(1'b1);
                    default: run_row(1'b0);
                endcase
                if ($urandom_range(0, 7) == 0)
                    wait_results_drained(0);
            end
        end
        wait_results_drained(SETTLE_CYCLES);

        $display("Moved %0d items (%0d counted in the random part) over %0d config phases,",
                 items_moved, effective_items - start_items, phase);
        $display("including clamped point counts and extreme gains; %0d results checked.",
                 results_seen);
        if (mismatches == 0)
            $display("[wave_equation_stencil_step_core] OK");
        else
            $display("[wave_equation_stencil_step_core] ERROR");
        $finish;
    end

endmodule
